/* sv/cptb_pkg.sv */
// Shared types, constants and helpers for the cascaded prescaled timer bank.
package cptb_pkg;

   // Bank geometry
   localparam int BANK_SIZE      = 4;
   localparam int TIMER_COUNT_DEF = 4;
   localparam int COUNT_W        = 16;
   localparam int RESIDUE_W      = 11;
   localparam int CTL_W          = 5;
   localparam int CYCLES_W       = 8;
   localparam int OVF_W          = 8;

   // Excess past the wrap point never exceeds 1277, so it fits in 11 bits
   localparam int EXCESS_W  = 11;
   localparam int DIV_STEPS = EXCESS_W;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_W = 8;
   localparam int RSP_W = 88;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD0  = 4'd4;

   // Control register bit positions
   localparam int CTL_START   = 0;
   localparam int CTL_CASCADE = 1;
   localparam int CTL_SEL_LO  = 2;
   localparam int CTL_IRQ_EN  = 4;

   // Prescaler: divide by 1, 64, 256, 1024
   localparam logic [3:0] PRESC_SHIFT [4] = '{4'd0, 4'd6, 4'd8, 4'd10};
   localparam logic [RESIDUE_W-1:0] PRESC_MASK [4] = '{11'h000, 11'h03F, 11'h0FF, 11'h3FF};

   // Controller states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CALC = 6'b000010,
      ST_WRAP = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic start;      // latch a new item
      logic calc;       // prescale and add for the current timer
      logic wrap;       // resolve overflow, commit or start division
      logic div_step;   // one restoring division step
      logic div_commit; // commit the divided wrap
      logic emit;       // load the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic last_timer;
      logic out_free;
   } sts_type;

   // Clamp an overflow count to the 8-bit result field
   function automatic logic [OVF_W-1:0] sat_count(input logic [11:0] k);
      logic [OVF_W-1:0] res;
      res = (k > 12'd255) ? 8'hFF : k[OVF_W-1:0];
      return res;
   endfunction

endpackage

/* sv/cptb_ctrl.sv */
// Sequencing state machine for the timer bank: walks the timers one by one.
module cptb_ctrl
   import cptb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // Take a new item only when idle
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            if (sts.need_div) begin
               state_in = ST_DIV;
            end else if (sts.last_timer) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.div_commit = 1'b1;
            state_in = sts.last_timer ? ST_OUT : ST_CALC;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/cptb_datapath.sv */
// Timer state, configuration registers, prescale/wrap arithmetic and result register.
module cptb_datapath
   import cptb_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

   // Configuration and timer state
   logic [CTL_W-1:0]     ctl_ff     [TIMER_COUNT];
   logic [COUNT_W-1:0]   reload_ff  [TIMER_COUNT];
   logic [COUNT_W-1:0]   counter_ff [TIMER_COUNT];
   logic [RESIDUE_W-1:0] residue_ff [TIMER_COUNT];

   // Per-item working registers
   logic [CYCLES_W-1:0]  cycles_ff;
   logic [IdxW-1:0]      idx_ff;
   logic                 below_ff;
   logic                 active_ff;
   logic [COUNT_W:0]     nv_ff;
   logic [BANK_SIZE-1:0] irq_ff;
   logic [OVF_W-1:0]     ovf_a_ff;
   logic [OVF_W-1:0]     ovf_b_ff;

   // Divider registers
   logic [EXCESS_W-1:0]  rem_ff;
   logic [EXCESS_W-1:0]  dividend_ff;
   logic [EXCESS_W-1:0]  quo_ff;
   logic [3:0]           dcnt_ff;

   // Result register
   logic [RSP_W-1:0]     rsp_tdata_ff;
   logic                 rsp_tvalid_ff;

   // Current timer's fields
   logic [CTL_W-1:0]     ctl;
   logic                 started, cascade, irq_en, active;
   logic [1:0]           sel;
   logic [RESIDUE_W-1:0] ticks, clocks, new_res;
   logic [COUNT_W:0]     nv;
   logic [COUNT_W-1:0]   reload;
   logic [COUNT_W:0]     period;
   logic [EXCESS_W-1:0]  excess;
   logic                 ovf, fits;
   logic [COUNT_W-1:0]   wrap_value, fin_value;
   logic [EXCESS_W:0]    trial;
   logic                 trial_ge;
   logic [EXCESS_W:0]    trial_diff;
   logic [11:0]          fin_k;
   logic                 advance;

   assign ctl     = ctl_ff[idx_ff];
   assign started = ctl[CTL_START];
   assign cascade = ctl[CTL_CASCADE];
   assign sel     = ctl[CTL_SEL_LO+1:CTL_SEL_LO];
   assign irq_en  = ctl[CTL_IRQ_EN];
   assign reload  = reload_ff[idx_ff];

   // Prescale: residue plus new ticks, split into clocks and remainder
   assign active  = started && (!cascade || below_ff);
   assign ticks   = residue_ff[idx_ff]
                    + (cascade ? 11'd1 : {{(RESIDUE_W-CYCLES_W){1'b0}}, cycles_ff});
   assign clocks  = ticks >> PRESC_SHIFT[sel];
   assign new_res = ticks & PRESC_MASK[sel];
   assign nv      = {1'b0, counter_ff[idx_ff]} + {{(COUNT_W+1-RESIDUE_W){1'b0}}, clocks};

   // Wrap: excess past 0x10000 against the reload period
   assign ovf        = active_ff && nv_ff[COUNT_W];
   assign excess     = nv_ff[EXCESS_W-1:0];
   assign period     = 17'h10000 - {1'b0, reload};
   assign fits       = {{(COUNT_W+1-EXCESS_W){1'b0}}, excess} < period;
   assign wrap_value = reload + {{(COUNT_W-EXCESS_W){1'b0}}, excess};
   assign fin_value  = reload + {{(COUNT_W-EXCESS_W){1'b0}}, rem_ff};
   assign fin_k      = {1'b0, quo_ff} + 12'd1;

   // Restoring division step
   assign trial      = {rem_ff, dividend_ff[EXCESS_W-1]};
   assign trial_ge   = {{(COUNT_W-EXCESS_W){1'b0}}, trial} >= period;
   assign trial_diff = trial - period[EXCESS_W:0];

   assign advance = (cmd.wrap && !(ovf && !fits)) || cmd.div_commit;

   // Status to the controller
   assign sts.need_div   = ovf && !fits;
   assign sts.div_last   = (dcnt_ff == 4'(DIV_STEPS - 1));
   assign sts.last_timer = (idx_ff == LastIdx);
   assign sts.out_free   = !rsp_tvalid_ff || rsp_tready;

   // Configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < TIMER_COUNT; n++) begin
            ctl_ff[n]    <= '0;
            reload_ff[n] <= '0;
         end
      end else if (csr_wr_en) begin
         for (int n = 0; n < TIMER_COUNT; n++) begin
            if (csr_index == CSR_CONTROL0 + CSR_IDX_W'(n)) begin
               ctl_ff[n] <= csr_wdata[CTL_W-1:0];
            end
            if (csr_index == CSR_RELOAD0 + CSR_IDX_W'(n)) begin
               reload_ff[n] <= csr_wdata[COUNT_W-1:0];
            end
         end
      end
   end

   // Counter and residue updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < TIMER_COUNT; n++) begin
            counter_ff[n] <= '0;
            residue_ff[n] <= '0;
         end
      end else begin
         if (cmd.calc && active) begin
            residue_ff[idx_ff] <= new_res;
         end
         if (cmd.wrap && active_ff) begin
            if (!nv_ff[COUNT_W]) begin
               counter_ff[idx_ff] <= nv_ff[COUNT_W-1:0];
            end else if (fits) begin
               counter_ff[idx_ff] <= wrap_value;
            end
         end
         if (cmd.div_commit) begin
            counter_ff[idx_ff] <= fin_value;
         end
      end
   end

   // Item sequencing, overflow bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         below_ff  <= 1'b0;
         active_ff <= 1'b0;
         irq_ff    <= '0;
         ovf_a_ff  <= '0;
         ovf_b_ff  <= '0;
      end else begin
         if (cmd.start) begin
            idx_ff   <= '0;
            below_ff <= 1'b0;
            irq_ff   <= '0;
            ovf_a_ff <= '0;
            ovf_b_ff <= '0;
         end
         if (cmd.calc) begin
            active_ff <= active;
         end
         if (cmd.wrap) begin
            below_ff <= ovf;
            if (ovf && irq_en) begin
               irq_ff[idx_ff] <= 1'b1;
            end
            if (ovf && fits && idx_ff == IdxW'(0)) begin
               ovf_a_ff <= 8'd1;
            end
            if (ovf && fits && TIMER_COUNT > 1 && idx_ff == IdxW'(1)) begin
               ovf_b_ff <= 8'd1;
            end
         end
         if (cmd.div_commit) begin
            if (idx_ff == IdxW'(0)) begin
               ovf_a_ff <= sat_count(fin_k);
            end
            if (TIMER_COUNT > 1 && idx_ff == IdxW'(1)) begin
               ovf_b_ff <= sat_count(fin_k);
            end
         end
         if (advance && idx_ff != LastIdx) begin
            idx_ff <= idx_ff + IdxW'(1);
         end
      end
   end

   // Payload-only registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cycles_ff <= req_tdata[CYCLES_W-1:0];
      end
      if (cmd.calc) begin
         nv_ff <= nv;
      end
      if (cmd.wrap) begin
         rem_ff      <= '0;
         dividend_ff <= excess;
         quo_ff      <= '0;
         dcnt_ff     <= '0;
      end
      if (cmd.div_step) begin
         rem_ff      <= trial_ge ? trial_diff[EXCESS_W-1:0] : trial[EXCESS_W-1:0];
         dividend_ff <= {dividend_ff[EXCESS_W-2:0], 1'b0};
         quo_ff      <= {quo_ff[EXCESS_W-2:0], trial_ge};
         dcnt_ff     <= dcnt_ff + 4'd1;
      end
   end

   // Counter fields of the result; timers past the bank read as zero
   logic [COUNT_W-1:0] count_out [BANK_SIZE];
   for (genvar g = 0; g < BANK_SIZE; g++) begin : g_count
      if (g < TIMER_COUNT) begin : g_live
         assign count_out[g] = counter_ff[g];
      end else begin : g_none
         assign count_out[g] = '0;
      end
   end

   // Result register: hold until transfer
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata_ff <= {4'b0, count_out[3], count_out[2], count_out[1], count_out[0],
                          ovf_b_ff, ovf_a_ff, irq_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* sv/cascaded_prescaled_timer_bank_top.sv */
// Top level of the cascaded prescaled timer bank: controller plus datapath.
//
//  Channel | Direction | Payload (lowest bit first)
//  req_    | in        | tdata: elapsed_cycles[7:0]
//  rsp_    | out       | tdata: irq_flags[3:0], sound_overflows_a[7:0], sound_overflows_b[7:0],
//          |           |        count_timer0..3[15:0] each, 4 zero pad bits
//  csr_    | in        | wr_en, index[3:0], wdata[15:0]; controls 0-3, reloads 4-7
//
// An item steps each timer through a prescale (CALC) and a wrap (WRAP) state, then waits in
// OUT until the output register is free; the next item is accepted only back in IDLE.
// A timer whose wrap period is no longer than its excess also passes through the
// bit-serial divider (DIV, FIN) that counts its overflows.
// Reset zeroes timers, residues, configuration and control state; data registers are not reset.
// A finished result waits in the output register; the next item is taken once it is loaded.
module cascaded_prescaled_timer_bank_top
   import cptb_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // elapsed_cycles
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // irq_flags, sound_overflows_a, sound_overflows_b, count_timer0..3, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   cptb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cptb_datapath #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

`ifndef SYNTH
   // An accepted item closes the input until its result is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again while an item is in progress");

   // Loading a result never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before transfer");

   // A loaded result is presented in the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("loaded result not presented");

   // At most one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the cascaded prescaled timer bank: directed and random timer steps.
module testbench;

   // Result transfer layout, lowest bit first: irq, overflows a/b, four counters, pad
   typedef struct packed {
      logic [3:0]       pad;
      logic [3:0][15:0] count;
      logic [7:0]       overflows_b;
      logic [7:0]       overflows_a;
      logic [3:0]       irq;
   } timer_result_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_STALLED,
      PERIODIC
   } stall_kind_type;

   // Control register bits
   localparam logic [4:0] T_STOP    = 5'b00000;
   localparam logic [4:0] T_START   = 5'b00001;
   localparam logic [4:0] T_CHAIN   = 5'b00010;
   localparam logic [4:0] T_DIV1    = 5'b00000;
   localparam logic [4:0] T_DIV64   = 5'b00100;
   localparam logic [4:0] T_DIV256  = 5'b01000;
   localparam logic [4:0] T_DIV1024 = 5'b01100;
   localparam logic [4:0] T_IRQ     = 5'b10000;

   // First register index that the block ignores
   localparam logic [3:0] CSR_UNUSED_FIRST = 4'd8;

   // Cycles to let pass after the last result, enough to cover an item with four divider runs
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 400000;

   logic clock;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // elapsed_cycles[7:0]
   logic [cptb_pkg::REQ_W-1:0]        req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // irq_flags[3:0], sound_overflows_a[7:0], sound_overflows_b[7:0], count_timer0..3, pad
   logic [cptb_pkg::RSP_W-1:0]        rsp_tdata;
   logic                              csr_wr_en = 1'b0;
   logic [cptb_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [cptb_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // Mirror of the timer bank
   logic [4:0]  timer_ctl     [4] = '{default: '0};
   logic [15:0] mirror_reload [4] = '{default: '0};
   logic [15:0] timer_count   [4] = '{default: '0};
   logic [10:0] timer_residue [4] = '{default: '0};

   timer_result_type expected_results [$];
   timer_result_type observed_result;
   timer_result_type oldest_expected;

   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left  = 4;
   stall_kind_type stall_mode  = ALWAYS_READY;

   cascaded_prescaled_timer_bank_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the mirrored timers by one step and return the result it produces
   function automatic timer_result_type advance_timers(input logic [7:0] elapsed);
      timer_result_type res;
      logic          below_wrapped;
      logic          wrapped;
      int unsigned   ticks, clocks, total, period, excess, shift, residue_next;
      int unsigned   wraps [4];
      int            n;
      res = '0;
      below_wrapped = 1'b0;
      for (n = 0; n < 4; n++) begin
         wraps[n] = 0;
         wrapped = 1'b0;
         case (timer_ctl[n][3:2])
            2'd0:    shift = 0;
            2'd1:    shift = 6;
            2'd2:    shift = 8;
            default: shift = 10;
         endcase
         // A chained timer only moves when the one below wrapped in this step
         if (timer_ctl[n][0] && !(timer_ctl[n][1] && !below_wrapped)) begin
            ticks = timer_residue[n] + (timer_ctl[n][1] ? 32'd1 : {24'd0, elapsed});
            clocks = ticks >> shift;
            total = timer_count[n] + clocks;
            if (total > 32'hFFFF) begin
               period = 32'h10000 - mirror_reload[n];
               excess = total - 32'h10000;
               wraps[n] = excess / period + 1;
               total = mirror_reload[n] + excess % period;
               wrapped = 1'b1;
               if (timer_ctl[n][4]) begin
                  res.irq[n] = 1'b1;
               end
            end
            residue_next = ticks & ((32'd1 << shift) - 32'd1);
            timer_count[n] = total[15:0];
            timer_residue[n] = residue_next[10:0];
         end
         below_wrapped = wrapped;
      end
      // Clamp the sound trigger counts to the field width
      res.overflows_a = (wraps[0] > 255) ? 8'hFF : wraps[0][7:0];
      res.overflows_b = (wraps[1] > 255) ? 8'hFF : wraps[1][7:0];
      for (n = 0; n < 4; n++) begin
         res.count[n] = timer_count[n];
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Compare each result transfer with the oldest pending step
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed_result = timer_result_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            $display("%0t ns: result 0x%h arrived with no step pending", $time, rsp_tdata);
            error_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            check_field("irq_flags", oldest_expected.irq, observed_result.irq);
            check_field("sound_overflows_a", oldest_expected.overflows_a,
                        observed_result.overflows_a);
            check_field("sound_overflows_b", oldest_expected.overflows_b,
                        observed_result.overflows_b);
            for (int t = 0; t < 4; t++) begin
               check_field($sformatf("count_timer%0d", t), oldest_expected.count[t],
                           observed_result.count[t]);
            end
            check_field("pad", oldest_expected.pad, observed_result.pad);
         end
      end
   end

   // Stall the result channel on a random pattern, redrawn whenever the low six bits of the cycle counter are zero
   always @(posedge clock) begin
      if (cycle_count[5:0] == 6'd0) begin
         stall_mode <= stall_kind_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         ALWAYS_READY:   rsp_tready <= 1'b1;
         COIN_FLIP:      rsp_tready <= 1'($urandom_range(0, 1));
         MOSTLY_STALLED: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:        rsp_tready <= (cycle_count[2:0] != 3'd5) && (cycle_count[2:0] != 3'd6);
      endcase
   end

   // Cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Send one step; the sender works in bursts with random gaps between them
   task automatic send_step(input logic [7:0] elapsed);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= elapsed;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(advance_timers(elapsed));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 8);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off the sender until every pending result has come and the block is idle
   task automatic await_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all eight registers plus one ignored index; timer 3 is the first element
   task automatic configure(input logic [3:0][4:0] ctl, input logic [3:0][15:0] reload);
      logic [15:0] word;
      int          i;
      for (i = 0; i < 4; i++) begin
         word = 16'($urandom_range(0, 16'hFFFF));
         word[4:0] = ctl[i];
         csr_wr_en <= 1'b1;
         csr_index <= cptb_pkg::CSR_CONTROL0 + 4'(i);
         csr_wdata <= word;
         @(posedge clock);
         timer_ctl[i] = word[4:0];
      end
      for (i = 0; i < 4; i++) begin
         csr_index <= cptb_pkg::CSR_RELOAD0 + 4'(i);
         csr_wdata <= reload[i];
         @(posedge clock);
         mirror_reload[i] = reload[i];
      end
      csr_index <= CSR_UNUSED_FIRST + 4'($urandom_range(0, 7));
      csr_wdata <= 16'($urandom_range(0, 16'hFFFF));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Nothing started after reset: all counters hold at zero
   task automatic test_idle_bank();
      send_step(8'h00);
      send_step(8'hFF);
      send_step(8'h5A);
      send_step(8'hA5);
   endtask

   // Run all timers at full rate until their first wrap, landing on high reloads
   task automatic test_first_wrap();
      int total;
      logic [7:0] elapsed;
      total = 0;
      await_results();
      configure({4{T_START | T_DIV1 | T_IRQ}}, {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      while (total < 32'h10000) begin
         elapsed = 8'($urandom_range(192, 255));
         send_step(elapsed);
         total += elapsed;
      end
   endtask

   // Chain timer 2 on timer 1 and timer 3 on timer 2; chaining on timer 0 never ticks
   task automatic test_cascade_chain();
      await_results();
      configure({T_START | T_CHAIN | T_DIV64 | T_IRQ, T_START | T_CHAIN | T_IRQ,
                 T_START | T_IRQ, T_START | T_CHAIN | T_IRQ},
                {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      send_step(8'd0);
      send_step(8'd1);
      send_step(8'd255);
      send_step(8'd128);
   endtask

   // A stopped timer breaks the chain above it
   task automatic test_stopped_link();
      await_results();
      configure({T_START | T_CHAIN, T_START | T_CHAIN | T_IRQ, T_STOP, T_START | T_DIV1},
                {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      send_step(8'd255);
      send_step(8'd7);
      await_results();
      configure({T_START | T_CHAIN, T_START | T_DIV1, T_START | T_CHAIN | T_IRQ, T_STOP},
                {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      send_step(8'd200);
   endtask

   // Build a large residue at a slow prescaler, then drop to full rate so the
   // old residue floods the counter and the sound counts saturate
   task automatic test_prescaler_switch();
      await_results();
      configure({T_START | T_DIV64, T_START | T_DIV256,
                 T_START | T_DIV1024, T_START | T_DIV1024 | T_IRQ},
                {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      repeat (4) send_step(8'd255);
      await_results();
      configure({5'b11111, T_START | T_CHAIN | T_DIV1 | T_IRQ,
                 T_START | T_DIV1, T_START | T_DIV1 | T_IRQ},
                {16'hF000, 16'hFFC0, 16'hFFFF, 16'hFFFF});
      send_step(8'd255);
   endtask

   // Random settings, each followed by a burst of random steps
   task automatic test_random_settings();
      logic [3:0][4:0]  ctl;
      logic [3:0][15:0] reload;
      logic [7:0]       elapsed;
      int               i, phase;
      for (phase = 0; phase < 6; phase++) begin
         for (i = 0; i < 4; i++) begin
            ctl[i] = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 3) != 0) begin
               ctl[i][0] = 1'b1;
            end
            // Keep reloads high so the counters stay close to their wrap point
            case ($urandom_range(0, 2))
               0:       reload[i] = 16'hFFFF - 16'($urandom_range(0, 16'h00FF));
               1:       reload[i] = 16'hFFFF - 16'($urandom_range(0, 16'h0FFF));
               default: reload[i] = 16'hFFFF - 16'($urandom_range(0, 16'h3FFF));
            endcase
         end
         await_results();
         configure(ctl, reload);
         repeat ($urandom_range(20, 32)) begin
            case ($urandom_range(0, 7))
               0:       elapsed = 8'h00;
               1:       elapsed = 8'hFF;
               default: elapsed = 8'($urandom_range(0, 255));
            endcase
            send_step(elapsed);
         end
      end
   endtask

   // Reload extremes: a full 0x10000 wrap period and a period of one
   task automatic test_reload_extremes();
      await_results();
      configure({4{T_START | T_DIV1 | T_IRQ}}, {16'h0000, 16'hFFFF, 16'h0001, 16'h0000});
      send_step(8'd255);
      send_step(8'd0);
      send_step(8'd200);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_bank();
      test_first_wrap();
      test_cascade_chain();
      test_stopped_link();
      test_prescaler_switch();
      test_random_settings();
      test_reload_extremes();
      await_results();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/cptb_pkg.sv
sv/cptb_ctrl.sv
sv/cptb_datapath.sv
sv/cascaded_prescaled_timer_bank_top.sv
sim/testbench.sv
